// ===== design/zvfe_pkg.sv =====
// zvfe_pkg: shared types and constants of the zigzag varint field encoder
// depends on nothing; imported by every design file of the block
`default_nettype none

package zvfe_pkg;

    // item kinds
    localparam logic [1:0] KIND_INT     = 2'd0;
    localparam logic [1:0] KIND_STR_HDR = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // wire types carried in the low bits of a key byte
    localparam logic [2:0] WIRE_INT = 3'd0;
    localparam logic [2:0] WIRE_STR = 3'd2;

    localparam int unsigned MAX_BYTES = 6;   // key plus five varint bytes
    localparam int unsigned VARINT_MAX = 5;

    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef logic [4:0] seq_t;
    typedef logic [2:0] cnt_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        new_record;
        logic [31:0] int_value;
        logic [31:0] str_length;
        logic [7:0]  data_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } byte_item_t;

    // run of encoded bytes, byte 0 leaves first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        cnt_t                      count;
    } run_t;

endpackage

`default_nettype wire

// ===== design/zvfe_encode.sv =====
// zvfe_encode: builds the byte run of one request (key, zigzag, varint split)
// depends on zvfe_pkg
`default_nettype none

module zvfe_encode
    import zvfe_pkg::*;
(
    input  wire req_item_t req,
    input  wire seq_t      key_seq,
    output run_t           run
);

    logic [31:0]                   zz;
    logic [31:0]                   val;
    logic [VARINT_MAX-1:0][6:0]    grp;
    cnt_t                          ngrp;
    logic [VARINT_MAX-1:0][7:0]    vbytes;
    logic [2:0]                    wire_type;

    // zigzag map of the signed value
    assign zz  = {req.int_value[30:0], 1'b0} ^ {32{req.int_value[31]}};
    assign val = (req.kind == KIND_INT) ? zz : req.str_length;

    assign grp[0] = val[6:0];
    assign grp[1] = val[13:7];
    assign grp[2] = val[20:14];
    assign grp[3] = val[27:21];
    assign grp[4] = {3'b000, val[31:28]};

    // minimal varint length, at least one byte
    always_comb
    begin
        if (val[31:28] != 4'd0)
            ngrp = 3'd5;
        else if (val[27:21] != 7'd0)
            ngrp = 3'd4;
        else if (val[20:14] != 7'd0)
            ngrp = 3'd3;
        else if (val[13:7] != 7'd0)
            ngrp = 3'd2;
        else
            ngrp = 3'd1;
    end

    always_comb
    begin
        for (int i = 0; i < VARINT_MAX; i++)
        begin
            vbytes[i] = {(3'(i) < (ngrp - 3'd1)), grp[i]};
        end
    end

    assign wire_type = (req.kind == KIND_INT) ? WIRE_INT : WIRE_STR;

    always_comb
    begin
        run.bytes = '0;
        run.count = 3'd0;
        unique case (req.kind)
            KIND_INT, KIND_STR_HDR:
            begin
                run.bytes = {vbytes, key_seq, wire_type};
                run.count = ngrp + 3'd1;
            end
            KIND_PAYLOAD:
            begin
                run.bytes[0] = req.data_byte;
                run.count    = 3'd1;
            end
            default:
            begin
                run.bytes = '0;
                run.count = 3'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/zigzag_varint_field_encoder_unit.sv =====
// zigzag_varint_field_encoder_unit: top level of the zigzag varint field encoder
// depends on zvfe_pkg and zvfe_encode
//
// usage
//   request channel (req_valid / req_ready / req_item): one record item per
//   request - an integer field, a string header with its length, or one
//   string payload byte; new_record restarts field numbering before the item
//   byte channel (byte_valid / byte_ready / byte_item): the encoded stream,
//   one byte per transfer, last_of_run marks the final byte of a request
//   a taken request waits in the input register, then moves into the run
//   register, from which its bytes leave; it holds the run register until
//   all its bytes have left through the single byte output port - 1 for a
//   payload byte, 2 to 6 for a field (key plus a 1 to 5 byte varint); a
//   request with an unused kind makes no byte and just passes through
//   the input register takes the next request while the run register drains,
//   and it moves into the run register in the cycle its last byte leaves, so
//   back to back requests of used kinds keep the byte channel busy every cycle
//   reset: both registers empty, field sequence number back to zero
//   stall: with byte_ready low the current byte holds; one further request
//   is held in the input register and req_ready then drops
`default_nettype none

module zigzag_varint_field_encoder_unit
    import zvfe_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        req_valid,
    output logic       req_ready,
    input  wire req_item_t req_item,

    output logic       byte_valid,
    input  wire        byte_ready,
    output byte_item_t byte_item
);

    // input register
    req_item_t req_reg;
    logic      req_full_reg;

    // field sequence number of the last key
    seq_t      field_seq_reg;
    seq_t      field_seq_next;
    seq_t      seq_base;

    // run register: bytes still to send and how many
    logic [MAX_BYTES-1:0][7:0] run_bytes_reg;
    logic [MAX_BYTES-1:0][7:0] run_bytes_next;
    cnt_t                      run_left_reg;
    cnt_t                      run_left_next;

    run_t enc_run;
    logic load;
    logic take;

    // key uses the sequence number as advanced by this item
    assign seq_base = req_reg.new_record ? 5'd0 : field_seq_reg;

    always_comb
    begin
        field_seq_next = seq_base;
        if (req_reg.kind == KIND_INT || req_reg.kind == KIND_STR_HDR)
            field_seq_next = seq_base + 5'd1;
    end

    zvfe_encode u_encode (
        .req     (req_reg),
        .key_seq (field_seq_next),
        .run     (enc_run)
    );

    assign take = byte_valid && byte_ready;
    // held request moves on when the run register is empty or sends its last byte
    assign load = req_full_reg &&
                  ((run_left_reg == 3'd0) || (byte_ready && run_left_reg == 3'd1));

    assign req_ready = !req_full_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            req_full_reg <= 1'b1;
        end
        else if (load)
        begin
            req_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_seq_reg <= 5'd0;
        else if (load)
            field_seq_reg <= field_seq_next;
    end

    // load a new run, or else shift the run down one byte per transfer
    always_comb
    begin
        run_bytes_next = run_bytes_reg;
        run_left_next  = run_left_reg;
        if (load)
        begin
            run_bytes_next = enc_run.bytes;
            run_left_next  = enc_run.count;
        end
        else if (take)
        begin
            run_bytes_next = run_bytes_reg >> 8;
            run_left_next  = run_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_left_reg <= 3'd0;
        else
            run_left_reg <= run_left_next;
    end

    always_ff @(posedge clk)
    begin
        run_bytes_reg <= run_bytes_next;
    end

    assign byte_valid            = (run_left_reg != 3'd0);
    assign byte_item.out_byte    = run_bytes_reg[0];
    assign byte_item.last_of_run = (run_left_reg == 3'd1);

endmodule

`default_nettype wire

// ===== design/zvfe_checker.sv =====
// zvfe_checker: port level assertions for the zigzag varint field encoder
// depends on zvfe_pkg; bound to zigzag_varint_field_encoder_unit
`default_nettype none

module zvfe_checker
    import zvfe_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        req_ready,
    input wire        byte_valid,
    input wire        byte_ready,
    input wire byte_item_t byte_item
);

    // a stalled byte holds
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
        else $error("stalled output byte changed or dropped");

    // a run never breaks off before its last byte
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && !byte_item.last_of_run |=> byte_valid)
        else $error("run ended without last_of_run");

    // an idle output side never blocks requests
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |-> req_ready)
        else $error("request stalled while output is empty");

endmodule

bind zigzag_varint_field_encoder_unit zvfe_checker u_zvfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req_ready),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
);

`default_nettype wire
